[rtl/sllp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sllp_pkg
// Shared types and constants of the static linked list pool: command and
// status codes, datapath micro-operations and the controller/datapath links.
// ----------------------------------------------------------------------------
package sllp_pkg;

    localparam int POOL_SIZE_DEF  = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int CMD_W    = 2;
    localparam int POS_W    = 4;
    localparam int VALUE_W  = 32;
    localparam int IDX_W    = 5;
    localparam int STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_NEW    = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_NO_SUCC = 2'd2
    } t_status;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_CAPTURE,
        OP_NEW_RD,
        OP_NEW_WR,
        OP_INS_RD_FH,
        OP_INS_RD_POS,
        OP_INS_WR_NODE,
        OP_INS_WR_POS,
        OP_DEL_RD_POS,
        OP_DEL_RD_NODE,
        OP_DEL_WR_POS,
        OP_DEL_WR_NODE,
        OP_READ_RD,
        OP_READ_RES,
        OP_RES_EMPTY,
        OP_RES_NOSUCC,
        OP_RES_BADREAD,
        OP_OUT
    } t_dp_op;

    typedef struct packed {
        t_cmd cmd;
        logic pos_ok;
        logic pool_empty;
        logic succ_end;
        logic clr_last;
        logic out_free;
    } t_dp_stat;

endpackage

[rtl/sllp_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sllp_req_if
// Command channel of the linked list pool: valid/ready plus command payload.
// ----------------------------------------------------------------------------
interface sllp_req_if;
    logic                               valid;
    logic                               ready;
    logic        [sllp_pkg::CMD_W-1:0]   cmd;
    logic        [sllp_pkg::POS_W-1:0]   position;
    logic signed [sllp_pkg::VALUE_W-1:0] value;

    modport source (output valid, output cmd, output position, output value, input ready);
    modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

[rtl/sllp_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sllp_rsp_if
// Result channel of the linked list pool: valid/ready plus result payload.
// ----------------------------------------------------------------------------
interface sllp_rsp_if;
    logic                                valid;
    logic                                ready;
    logic        [sllp_pkg::IDX_W-1:0]    node_index;
    logic signed [sllp_pkg::VALUE_W-1:0]  data_out;
    logic        [sllp_pkg::IDX_W-1:0]    link_out;
    logic        [sllp_pkg::STATUS_W-1:0] status;

    modport source (output valid, output node_index, output data_out, output link_out,
                    output status, input ready);
    modport sink   (input valid, input node_index, input data_out, input link_out,
                    input status, output ready);
endinterface

[rtl/static_linked_list_pool.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// static_linked_list_pool
// Linked lists in a fixed node pool with a free list, addressed by node index.
// ----------------------------------------------------------------------------
// usage
//   i_req carries one command per transfer (new, insert after, delete after,
//   read); o_rsp returns exactly one result transfer per command, in order.
//   one command is worked at a time; i_req.ready is high while the block is
//   idle. each command is a sequence of single-port accesses to the link
//   memory (one read or one write per cycle, registered read data). the
//   next command can be taken in the cycle after its predecessor's result
//   is loaded into the output register.
//   after reset the block runs a clearing pass that chains every node onto
//   the free list; i_req.ready stays low meanwhile.
//   the result sits in an output register: a stalled receiver does not stop
//   the next command, only its result load waits until the register is free.
// ----------------------------------------------------------------------------
module static_linked_list_pool #(
    parameter int POOL_SIZE  = sllp_pkg::POOL_SIZE_DEF,
    parameter int DATA_WIDTH = sllp_pkg::DATA_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sllp_req_if.sink   i_req,
    sllp_rsp_if.source o_rsp
);

    sllp_pkg::t_dp_op   op;
    sllp_pkg::t_dp_stat stat;

    sllp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_stat  (stat),
        .o_op    (op)
    );

    sllp_datapath #(
        .POOL_SIZE  (POOL_SIZE),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_op    (op),
        .o_stat  (stat)
    );

endmodule

[rtl/sllp_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sllp_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module sllp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/sllp_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sllp_datapath
// Link and data memories, free list head, result staging and the output
// register of the linked list pool; executes one micro-operation per cycle.
// ----------------------------------------------------------------------------
module sllp_datapath #(
    parameter int POOL_SIZE  = sllp_pkg::POOL_SIZE_DEF,
    parameter int DATA_WIDTH = sllp_pkg::DATA_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    sllp_req_if.sink           i_req,
    sllp_rsp_if.source         o_rsp,
    input  sllp_pkg::t_dp_op   i_op,
    output sllp_pkg::t_dp_stat o_stat
);

    localparam int AW = $clog2(POOL_SIZE);
    localparam int LW = $clog2(POOL_SIZE + 1);
    localparam logic [LW-1:0] END_IDX = LW'(POOL_SIZE);
    localparam logic [AW-1:0] LAST_ADDR = AW'(POOL_SIZE - 1);

    sllp_pkg::t_cmd             r_cmd;
    logic [sllp_pkg::POS_W-1:0] r_pos;
    logic [DATA_WIDTH-1:0]      r_value;
    logic [LW-1:0]              r_fh;
    logic [LW-1:0]              r_node;
    logic [LW-1:0]              r_link;
    logic [AW-1:0]              r_clr;

    logic [LW-1:0]              r_res_idx;
    logic [DATA_WIDTH-1:0]      r_res_data;
    logic [LW-1:0]              r_res_link;
    sllp_pkg::t_status          r_res_status;

    logic                          r_out_valid;
    logic [sllp_pkg::IDX_W-1:0]    r_out_idx;
    logic [sllp_pkg::VALUE_W-1:0]  r_out_data;
    logic [sllp_pkg::IDX_W-1:0]    r_out_link;
    logic [sllp_pkg::STATUS_W-1:0] r_out_status;

    logic [AW-1:0]         pos_addr;
    logic [AW-1:0]         fh_addr;
    logic [AW-1:0]         node_addr;
    logic                  link_we;
    logic [AW-1:0]         link_waddr;
    logic [LW-1:0]         link_wdata;
    logic [AW-1:0]         link_raddr;
    logic [LW-1:0]         link_rdata;
    logic                  data_we;
    logic [AW-1:0]         data_raddr;
    logic [DATA_WIDTH-1:0] data_rdata;
    logic                  out_free;

    assign pos_addr  = AW'(r_pos);
    assign fh_addr   = AW'(r_fh);
    assign node_addr = AW'(r_node);
    assign out_free  = !r_out_valid || o_rsp.ready;

    // memory port control
    always_comb begin
        link_we    = 1'b0;
        link_waddr = fh_addr;
        link_wdata = r_fh;
        link_raddr = fh_addr;
        data_we    = 1'b0;
        data_raddr = pos_addr;
        case (i_op)
            sllp_pkg::OP_CLEAR: begin
                link_we    = 1'b1;
                link_waddr = r_clr;
                link_wdata = LW'(r_clr) + LW'(1);
            end
            sllp_pkg::OP_INS_RD_FH: begin
                data_we = 1'b1;
            end
            sllp_pkg::OP_NEW_WR: begin
                link_we    = 1'b1;
                link_wdata = END_IDX;
            end
            sllp_pkg::OP_INS_RD_POS, sllp_pkg::OP_DEL_RD_POS: begin
                link_raddr = pos_addr;
            end
            sllp_pkg::OP_READ_RD: begin
                link_raddr = pos_addr;
                data_raddr = pos_addr;
            end
            sllp_pkg::OP_INS_WR_NODE: begin
                link_we    = 1'b1;
                link_wdata = link_rdata;
            end
            sllp_pkg::OP_INS_WR_POS: begin
                link_we    = 1'b1;
                link_waddr = pos_addr;
            end
            sllp_pkg::OP_DEL_RD_NODE: begin
                link_raddr = AW'(link_rdata);
                data_raddr = AW'(link_rdata);
            end
            sllp_pkg::OP_DEL_WR_POS: begin
                link_we    = 1'b1;
                link_waddr = pos_addr;
                link_wdata = link_rdata;
            end
            sllp_pkg::OP_DEL_WR_NODE: begin
                link_we    = 1'b1;
                link_waddr = node_addr;
            end
            default: begin
            end
        endcase
    end

    sllp_ram #(
        .WIDTH (LW),
        .DEPTH (POOL_SIZE)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    sllp_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (POOL_SIZE)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (fh_addr),
        .i_wdata (r_value),
        .i_raddr (data_raddr),
        .o_rdata (data_rdata)
    );

    // control state: free head, clear counter, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fh        <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (i_op)
                sllp_pkg::OP_CLEAR:      r_clr <= r_clr + AW'(1);
                sllp_pkg::OP_NEW_WR:     r_fh  <= link_rdata;
                sllp_pkg::OP_INS_WR_POS: r_fh  <= r_link;
                sllp_pkg::OP_DEL_WR_NODE: r_fh <= r_node;
                default: begin
                end
            endcase
            if (i_op == sllp_pkg::OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (i_op)
            sllp_pkg::OP_CAPTURE: begin
                r_cmd   <= sllp_pkg::t_cmd'(i_req.cmd);
                r_pos   <= i_req.position;
                r_value <= DATA_WIDTH'(i_req.value);
            end
            sllp_pkg::OP_NEW_WR: begin
                r_res_idx    <= r_fh;
                r_res_data   <= '0;
                r_res_link   <= END_IDX;
                r_res_status <= sllp_pkg::ST_OK;
            end
            sllp_pkg::OP_INS_RD_POS: begin
                r_link <= link_rdata;
            end
            sllp_pkg::OP_INS_WR_POS: begin
                r_res_idx    <= r_fh;
                r_res_data   <= '0;
                r_res_link   <= END_IDX;
                r_res_status <= sllp_pkg::ST_OK;
            end
            sllp_pkg::OP_DEL_RD_NODE: begin
                r_node <= link_rdata;
            end
            sllp_pkg::OP_DEL_WR_POS: begin
                r_res_data <= data_rdata;
            end
            sllp_pkg::OP_DEL_WR_NODE: begin
                r_res_idx    <= r_node;
                r_res_link   <= END_IDX;
                r_res_status <= sllp_pkg::ST_OK;
            end
            sllp_pkg::OP_READ_RES: begin
                r_res_idx    <= LW'(r_pos);
                r_res_data   <= data_rdata;
                r_res_link   <= link_rdata;
                r_res_status <= sllp_pkg::ST_OK;
            end
            sllp_pkg::OP_RES_EMPTY: begin
                r_res_idx    <= END_IDX;
                r_res_data   <= '0;
                r_res_link   <= END_IDX;
                r_res_status <= sllp_pkg::ST_EMPTY;
            end
            sllp_pkg::OP_RES_NOSUCC: begin
                r_res_idx    <= END_IDX;
                r_res_data   <= '0;
                r_res_link   <= END_IDX;
                r_res_status <= sllp_pkg::ST_NO_SUCC;
            end
            sllp_pkg::OP_RES_BADREAD: begin
                r_res_idx    <= END_IDX;
                r_res_data   <= '0;
                r_res_link   <= END_IDX;
                r_res_status <= sllp_pkg::ST_OK;
            end
            sllp_pkg::OP_OUT: begin
                r_out_idx    <= sllp_pkg::IDX_W'(r_res_idx);
                r_out_data   <= sllp_pkg::VALUE_W'(signed'(r_res_data));
                r_out_link   <= sllp_pkg::IDX_W'(r_res_link);
                r_out_status <= r_res_status;
            end
            default: begin
            end
        endcase
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.node_index = r_out_idx;
    assign o_rsp.data_out   = r_out_data;
    assign o_rsp.link_out   = r_out_link;
    assign o_rsp.status     = r_out_status;

    assign o_stat.cmd        = r_cmd;
    assign o_stat.pos_ok     = ({28'd0, r_pos} < 32'(POOL_SIZE));
    assign o_stat.pool_empty = (r_fh >= END_IDX);
    assign o_stat.succ_end   = (link_rdata >= END_IDX);
    assign o_stat.clr_last   = (r_clr == LAST_ADDR);
    assign o_stat.out_free   = out_free;

    a_fh_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fh <= END_IDX)
        else $error("free head beyond end marker");

    a_out_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == sllp_pkg::OP_OUT) |-> out_free)
        else $error("result loaded over an untaken transfer");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == sllp_pkg::OP_OUT) |=> r_out_valid)
        else $error("loaded result not presented");

    a_del_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == sllp_pkg::OP_DEL_WR_NODE) |=> (r_fh == $past(r_node)))
        else $error("deleted node not pushed on free list");

endmodule

[rtl/sllp_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sllp_ctrl
// Controller of the linked list pool: clearing pass after reset, then one
// command at a time as a short sequence of datapath micro-operations.
// ----------------------------------------------------------------------------
module sllp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    sllp_req_if.sink           i_req,
    input  sllp_pkg::t_dp_stat i_stat,
    output sllp_pkg::t_dp_op   o_op
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_NEW_W,
        S_INS_B,
        S_INS_C,
        S_INS_D,
        S_DEL_B,
        S_DEL_C,
        S_DEL_D,
        S_RD_B,
        S_FIN
    } t_state;

    t_state           r_state;
    t_state           n_state;
    sllp_pkg::t_dp_op op;

    always_comb begin
        n_state = r_state;
        op      = sllp_pkg::OP_NONE;
        case (r_state)
            S_CLEAR: begin
                op = sllp_pkg::OP_CLEAR;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    op      = sllp_pkg::OP_CAPTURE;
                    n_state = S_START;
                end
            end
            S_START: begin
                case (i_stat.cmd)
                    sllp_pkg::CMD_NEW: begin
                        if (i_stat.pool_empty) begin
                            op      = sllp_pkg::OP_RES_EMPTY;
                            n_state = S_FIN;
                        end else begin
                            op      = sllp_pkg::OP_NEW_RD;
                            n_state = S_NEW_W;
                        end
                    end
                    sllp_pkg::CMD_INSERT: begin
                        if (!i_stat.pos_ok) begin
                            op      = sllp_pkg::OP_RES_NOSUCC;
                            n_state = S_FIN;
                        end else if (i_stat.pool_empty) begin
                            op      = sllp_pkg::OP_RES_EMPTY;
                            n_state = S_FIN;
                        end else begin
                            op      = sllp_pkg::OP_INS_RD_FH;
                            n_state = S_INS_B;
                        end
                    end
                    sllp_pkg::CMD_DELETE: begin
                        if (!i_stat.pos_ok) begin
                            op      = sllp_pkg::OP_RES_NOSUCC;
                            n_state = S_FIN;
                        end else begin
                            op      = sllp_pkg::OP_DEL_RD_POS;
                            n_state = S_DEL_B;
                        end
                    end
                    default: begin
                        if (!i_stat.pos_ok) begin
                            op      = sllp_pkg::OP_RES_BADREAD;
                            n_state = S_FIN;
                        end else begin
                            op      = sllp_pkg::OP_READ_RD;
                            n_state = S_RD_B;
                        end
                    end
                endcase
            end
            S_NEW_W: begin
                op      = sllp_pkg::OP_NEW_WR;
                n_state = S_FIN;
            end
            S_INS_B: begin
                op      = sllp_pkg::OP_INS_RD_POS;
                n_state = S_INS_C;
            end
            S_INS_C: begin
                op      = sllp_pkg::OP_INS_WR_NODE;
                n_state = S_INS_D;
            end
            S_INS_D: begin
                op      = sllp_pkg::OP_INS_WR_POS;
                n_state = S_FIN;
            end
            S_DEL_B: begin
                if (i_stat.succ_end) begin
                    op      = sllp_pkg::OP_RES_NOSUCC;
                    n_state = S_FIN;
                end else begin
                    op      = sllp_pkg::OP_DEL_RD_NODE;
                    n_state = S_DEL_C;
                end
            end
            S_DEL_C: begin
                op      = sllp_pkg::OP_DEL_WR_POS;
                n_state = S_DEL_D;
            end
            S_DEL_D: begin
                op      = sllp_pkg::OP_DEL_WR_NODE;
                n_state = S_FIN;
            end
            S_RD_B: begin
                op      = sllp_pkg::OP_READ_RES;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    op      = sllp_pkg::OP_OUT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_op        = op;
    assign i_req.ready = (r_state == S_IDLE);

endmodule
